FILE: rtl/core/jts_pkg.sv
// ----------------------------------------------------------------------------
// jts_pkg: shared types and constants of the JSON token serializer
//
// Event codes, grammar states, string roles, sequencer states and the
// character constants and literal words that the serializer writes.
// ----------------------------------------------------------------------------
package jts_pkg;

    // Width of the integer port; only the low NUMBER_WIDTH bits are used.
    localparam int NUM_PORT_W = 64;

    // Token event codes.
    typedef enum logic [3:0] {
        MODE_OBJ_START = 4'd0,
        MODE_OBJ_END   = 4'd1,
        MODE_ARR_START = 4'd2,
        MODE_ARR_END   = 4'd3,
        MODE_INT       = 4'd4,
        MODE_BOOL      = 4'd5,
        MODE_NULL      = 4'd6,
        MODE_STR_BEGIN = 4'd7,
        MODE_STR_BYTE  = 4'd8,
        MODE_STR_END   = 4'd9
    } t_mode;

    // Grammar states of the writer.
    typedef enum logic [2:0] {
        G_START    = 3'd0,
        G_OBJ      = 3'd1,
        G_OBJ_KEY  = 3'd2,
        G_OBJ_VAL  = 3'd3,
        G_ARR      = 3'd4,
        G_ARR_ITEM = 3'd5,
        G_END      = 3'd6,
        G_ERR      = 3'd7
    } t_gram;

    // Where an open string sits in the document.
    typedef enum logic [1:0] {
        ROLE_TOP  = 2'd0,
        ROLE_ITEM = 2'd1,
        ROLE_KEY  = 2'd2,
        ROLE_VAL  = 2'd3
    } t_role;

    // Kind of an open container on the nesting stack.
    localparam logic KIND_OBJ = 1'b0;
    localparam logic KIND_ARR = 1'b1;

    // What an accepted event writes after its optional separator.
    typedef enum logic [1:0] {
        BODY_CHAR = 2'd0,
        BODY_WORD = 2'd1,
        BODY_INT  = 2'd2
    } t_body;

    // Literal words.
    typedef enum logic [1:0] {
        WORD_TRUE  = 2'd0,
        WORD_FALSE = 2'd1,
        WORD_NULL  = 2'd2
    } t_word;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FAULT,
        ST_CONV,
        ST_SKIP,
        ST_COMMA,
        ST_SIGN,
        ST_DIGIT,
        ST_CHAR,
        ST_COLON,
        ST_WORD
    } t_state;

    // Character constants.
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // Character at position idx of a literal word.
    function automatic logic [7:0] word_char(input t_word w, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (w)
            WORD_TRUE: begin
                unique case (idx)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    default: c = 8'h65;
                endcase
            end
            WORD_FALSE: begin
                unique case (idx)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    default: c = 8'h65;
                endcase
            end
            default: begin
                unique case (idx)
                    3'd0:    c = 8'h6E;
                    3'd1:    c = 8'h75;
                    default: c = 8'h6C;
                endcase
            end
        endcase
        return c;
    endfunction

    // Index of the final character of a literal word.
    function automatic logic [2:0] word_last(input t_word w);
        logic [2:0] n;
        n = (w == WORD_FALSE) ? 3'd4 : 3'd3;
        return n;
    endfunction

endpackage

FILE: rtl/core/jts_ram.sv
// ----------------------------------------------------------------------------
// jts_ram: generic single-write, single-read RAM
//
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module jts_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/json_token_serializer_top.sv
// ----------------------------------------------------------------------------
// json_token_serializer_top: streaming JSON writer driven by token events
//
// Input channel (i_valid/o_ready) takes one token event per beat; output
// channel (o_valid/i_ready) gives one result per beat, one character each.
// o_ready is high only while the sequencer is idle; one event is in work at
// a time. A legal event passes a check state and then writes its characters
// in turn, a comma first where one is needed. An integer first runs a
// shift-and-add-3 BCD conversion through a shared adjust unit, one bit per
// cycle, then drops leading zero digits, keeping at least one, and writes
// an optional sign and then the digits.
// An illegal event, or any event after a fault, gives one beat with no
// character and the fault flag set. The last beat of each event has o_last.
// The result register lets the sequencer run ahead one beat; when the
// receiver stalls, the sequencer holds until the register is taken.
// Reset (synchronous, active low) returns the grammar to its start state,
// empties the nesting stack and clears the fault; the stack RAM needs no
// clearing since only pushed entries are ever read.
// ----------------------------------------------------------------------------
module json_token_serializer_top
    import jts_pkg::*;
#(
    parameter int NEST_DEPTH   = 32,
    parameter int NUMBER_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3:0]            i_mode,
    input  logic [NUM_PORT_W-1:0] i_number,
    input  logic                  i_truth,
    input  logic [7:0]            i_text_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_out_char,
    output logic                  o_char_valid,
    output logic                  o_fault,
    output logic                  o_last
);

    localparam int CW     = $clog2(NEST_DEPTH + 1);
    localparam int AW     = $clog2(NEST_DEPTH);
    localparam int DIGITS = (NUMBER_WIDTH * 3) / 10 + 1;
    localparam int DW     = 4 * DIGITS;
    localparam int IW     = $clog2(NUMBER_WIDTH);
    localparam int LW     = $clog2(DIGITS + 1);

    // Control state.
    t_state          r_state, n_state;
    t_gram           r_gram, n_gram;
    logic [CW-1:0]   r_count, n_count;
    logic            r_in_text, n_in_text;
    t_role           r_role, n_role;
    logic            r_sticky, n_sticky;
    logic            r_out_valid, n_out_valid;

    // Event payload and work registers.
    logic [3:0]              r_mode, n_mode;
    logic                    r_truth, n_truth;
    logic [7:0]              r_byte, n_byte;
    logic                    r_neg, n_neg;
    logic [NUMBER_WIDTH-1:0] r_bin, n_bin;
    logic [DW-1:0]           r_bcd, n_bcd;
    logic [IW-1:0]           r_iter, n_iter;
    logic [LW-1:0]           r_left, n_left;
    logic                    r_comma, n_comma;
    logic [7:0]              r_char, n_char;
    logic                    r_colon, n_colon;
    t_body                   r_body, n_body;
    t_word                   r_word, n_word;
    logic [2:0]              r_widx, n_widx;

    // Result register.
    logic [7:0] r_out_char, n_out_char;
    logic       r_char_valid, n_char_valid;
    logic       r_fault, n_fault;
    logic       r_last, n_last;

    // Stack RAM and conversion signals.
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic                    ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic                    ram_rdata;
    logic [DW-1:0]           bcd_adj;
    logic [3:0]              top_digit;
    logic [NUMBER_WIDTH-1:0] num_lo;
    logic                    out_free;

    // Nesting stack: one kind bit per open container.
    jts_ram #(
        .WIDTH (1),
        .DEPTH (NEST_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The read port always looks at the entry below the top, the parent
    // that a close returns to.
    assign ram_raddr = AW'(r_count - CW'(2));
    assign ram_waddr = AW'(r_count);

    // Shared add-3 adjust unit of the binary to BCD conversion.
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                          : r_bcd[4*k +: 4];
        end
    end

    assign top_digit = r_bcd[DW-1 -: 4];
    assign num_lo    = i_number[NUMBER_WIDTH-1:0];
    assign out_free  = !r_out_valid || i_ready;

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_char_valid;
    assign o_fault      = r_fault;
    assign o_last       = r_last;

    // Sequencer: next state, stack updates and result beats.
    always_comb begin
        logic       bad;
        logic       str_inner;
        logic       emit;
        logic [7:0] e_char;
        logic       e_valid;
        logic       e_fault;
        logic       e_last;

        n_state     = r_state;
        n_gram      = r_gram;
        n_count     = r_count;
        n_in_text   = r_in_text;
        n_role      = r_role;
        n_sticky    = r_sticky;
        n_mode      = r_mode;
        n_truth     = r_truth;
        n_byte      = r_byte;
        n_neg       = r_neg;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_iter      = r_iter;
        n_left      = r_left;
        n_comma     = r_comma;
        n_char      = r_char;
        n_colon     = r_colon;
        n_body      = r_body;
        n_word      = r_word;
        n_widx      = r_widx;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_char_valid = r_char_valid;
        n_fault     = r_fault;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_wdata   = KIND_OBJ;
        bad         = 1'b0;
        str_inner   = (r_mode == MODE_STR_BYTE) || (r_mode == MODE_STR_END);
        emit        = 1'b0;
        e_char      = 8'h00;
        e_valid     = 1'b1;
        e_fault     = 1'b0;
        e_last      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mode  = i_mode;
                    n_truth = i_truth;
                    n_byte  = i_text_byte;
                    n_neg   = num_lo[NUMBER_WIDTH-1];
                    n_bin   = num_lo[NUMBER_WIDTH-1] ? (~num_lo + 1'b1) : num_lo;
                    n_state = ST_CHECK;
                end
            end

            ST_CHECK: begin
                // Legality of the event in the current grammar state.
                bad = r_sticky || (r_gram == G_ERR) || (r_mode > MODE_STR_END)
                      || (r_in_text != str_inner);
                unique case (r_mode)
                    MODE_OBJ_START, MODE_ARR_START: begin
                        if (!(r_gram == G_START || r_gram == G_OBJ_KEY ||
                              r_gram == G_ARR || r_gram == G_ARR_ITEM) ||
                            (r_count >= CW'(NEST_DEPTH))) begin
                            bad = 1'b1;
                        end
                    end
                    MODE_OBJ_END: begin
                        if (!(r_gram == G_OBJ || r_gram == G_OBJ_VAL) ||
                            (r_count == '0)) begin
                            bad = 1'b1;
                        end
                    end
                    MODE_ARR_END: begin
                        if (!(r_gram == G_ARR || r_gram == G_ARR_ITEM) ||
                            (r_count == '0)) begin
                            bad = 1'b1;
                        end
                    end
                    MODE_INT, MODE_BOOL, MODE_NULL: begin
                        if (!(r_gram == G_START || r_gram == G_ARR ||
                              r_gram == G_ARR_ITEM || r_gram == G_OBJ_KEY)) begin
                            bad = 1'b1;
                        end
                    end
                    MODE_STR_BEGIN: begin
                        if (r_gram == G_END) begin
                            bad = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                n_comma = 1'b0;
                n_colon = 1'b0;
                n_body  = BODY_CHAR;
                n_widx  = 3'd0;

                if (bad) begin
                    n_sticky = 1'b1;
                    n_gram   = G_ERR;
                    n_state  = ST_FAULT;
                end else begin
                    // Grammar and stack updates of a legal event.
                    unique case (r_mode)
                        MODE_OBJ_START, MODE_ARR_START: begin
                            n_comma   = (r_gram == G_ARR_ITEM);
                            ram_we    = 1'b1;
                            if (r_mode == MODE_OBJ_START) begin
                                n_char    = CH_LBRACE;
                                ram_wdata = KIND_OBJ;
                                n_gram    = G_OBJ;
                            end else begin
                                n_char    = CH_LBRACK;
                                ram_wdata = KIND_ARR;
                                n_gram    = G_ARR;
                            end
                            n_count = r_count + 1'b1;
                        end
                        MODE_OBJ_END, MODE_ARR_END: begin
                            n_char  = (r_mode == MODE_OBJ_END) ? CH_RBRACE : CH_RBRACK;
                            n_count = r_count - 1'b1;
                            if (r_count == CW'(1)) begin
                                n_gram = G_END;
                            end else begin
                                n_gram = (ram_rdata == KIND_ARR) ? G_ARR_ITEM : G_OBJ_VAL;
                            end
                        end
                        MODE_INT, MODE_BOOL, MODE_NULL: begin
                            n_comma = (r_gram == G_ARR_ITEM);
                            priority if (r_gram == G_START) begin
                                n_gram = G_END;
                            end else if (r_gram == G_OBJ_KEY) begin
                                n_gram = G_OBJ_VAL;
                            end else begin
                                n_gram = G_ARR_ITEM;
                            end
                            priority if (r_mode == MODE_INT) begin
                                n_body = BODY_INT;
                            end else if (r_mode == MODE_BOOL) begin
                                n_body = BODY_WORD;
                                n_word = r_truth ? WORD_TRUE : WORD_FALSE;
                            end else begin
                                n_body = BODY_WORD;
                                n_word = WORD_NULL;
                            end
                        end
                        MODE_STR_BEGIN: begin
                            n_comma   = (r_gram == G_ARR_ITEM) || (r_gram == G_OBJ_VAL);
                            n_char    = CH_QUOTE;
                            n_in_text = 1'b1;
                            priority if (r_gram == G_START) begin
                                n_role = ROLE_TOP;
                            end else if (r_gram == G_ARR || r_gram == G_ARR_ITEM) begin
                                n_role = ROLE_ITEM;
                            end else if (r_gram == G_OBJ || r_gram == G_OBJ_VAL) begin
                                n_role = ROLE_KEY;
                            end else begin
                                n_role = ROLE_VAL;
                            end
                        end
                        MODE_STR_BYTE: begin
                            n_char = r_byte;
                        end
                        default: begin
                            // String end: close quote, then a colon after a key.
                            n_char    = CH_QUOTE;
                            n_colon   = (r_role == ROLE_KEY);
                            n_in_text = 1'b0;
                            unique case (r_role)
                                ROLE_TOP:  n_gram = G_END;
                                ROLE_ITEM: n_gram = G_ARR_ITEM;
                                ROLE_KEY:  n_gram = G_OBJ_KEY;
                                default:   n_gram = G_OBJ_VAL;
                            endcase
                        end
                    endcase

                    // Integers convert first; everything else starts writing.
                    if (r_mode == MODE_INT) begin
                        n_bcd   = '0;
                        n_iter  = IW'(NUMBER_WIDTH - 1);
                        n_left  = LW'(DIGITS);
                        n_state = ST_CONV;
                    end else if (n_comma) begin
                        n_state = ST_COMMA;
                    end else if (n_body == BODY_WORD) begin
                        n_state = ST_WORD;
                    end else begin
                        n_state = ST_CHAR;
                    end
                end
            end

            ST_FAULT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = 8'h00;
                    e_valid = 1'b0;
                    e_fault = 1'b1;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_CONV: begin
                // One magnitude bit per cycle into the BCD register.
                n_bin = r_bin << 1;
                n_bcd = {bcd_adj[DW-2:0], r_bin[NUMBER_WIDTH-1]};
                if (r_iter == '0) begin
                    n_state = ST_SKIP;
                end else begin
                    n_iter = r_iter - 1'b1;
                end
            end

            ST_SKIP: begin
                // Drop leading zero digits, keeping at least one.
                if ((top_digit == 4'd0) && (r_left > LW'(1))) begin
                    n_bcd  = r_bcd << 4;
                    n_left = r_left - 1'b1;
                end else if (r_comma) begin
                    n_state = ST_COMMA;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end

            ST_COMMA: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_char = CH_COMMA;
                    unique case (r_body)
                        BODY_INT:  n_state = r_neg ? ST_SIGN : ST_DIGIT;
                        BODY_WORD: n_state = ST_WORD;
                        default:   n_state = ST_CHAR;
                    endcase
                end
            end

            ST_SIGN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = CH_MINUS;
                    n_state = ST_DIGIT;
                end
            end

            ST_DIGIT: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_char = CH_ZERO | {4'd0, top_digit};
                    e_last = (r_left == LW'(1));
                    n_bcd  = r_bcd << 4;
                    n_left = r_left - 1'b1;
                    if (r_left == LW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_CHAR: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = r_char;
                    e_last  = !r_colon;
                    n_state = r_colon ? ST_COLON : ST_IDLE;
                end
            end

            ST_COLON: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = CH_COLON;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_WORD: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_char = word_char(r_word, r_widx);
                    e_last = (r_widx == word_last(r_word));
                    n_widx = r_widx + 1'b1;
                    if (r_widx == word_last(r_word)) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Load the result register with this cycle's beat.
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_char   = e_char;
            n_char_valid = e_valid;
            n_fault      = e_fault;
            n_last       = e_last;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gram      <= G_START;
            r_count     <= '0;
            r_in_text   <= 1'b0;
            r_role      <= ROLE_TOP;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gram      <= n_gram;
            r_count     <= n_count;
            r_in_text   <= n_in_text;
            r_role      <= n_role;
            r_sticky    <= n_sticky;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and work registers.
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_truth      <= n_truth;
        r_byte       <= n_byte;
        r_neg        <= n_neg;
        r_bin        <= n_bin;
        r_bcd        <= n_bcd;
        r_iter       <= n_iter;
        r_left       <= n_left;
        r_comma      <= n_comma;
        r_char       <= n_char;
        r_colon      <= n_colon;
        r_body       <= n_body;
        r_word       <= n_word;
        r_widx       <= n_widx;
        r_out_char   <= n_out_char;
        r_char_valid <= n_char_valid;
        r_fault      <= n_fault;
        r_last       <= n_last;
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the JSON token serializer
//
// One document is written per run: a top-level array that stays open while
// directed values, random well-formed content and full-depth nesting pass
// through it. The run ends with a stack overflow, which sets the sticky
// fault, followed by arbitrary events that must each give a single fault
// beat. Every accepted event is fed to a behavioral serializer that queues
// the characters it expects; each output beat is compared field by field
// with the oldest queued character.
// ----------------------------------------------------------------------------
module tb;
    import jts_pkg::*;

    localparam int NEST         = 32;
    localparam int NUMW         = 64;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;

    // Event codes that carry no meaning.
    localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
    localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

    // One expected output beat.
    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       fault;
        logic       last;
    } char_beat_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [3:0]            i_mode      = 4'd0;
    logic [NUM_PORT_W-1:0] i_number    = '0;
    logic                  i_truth     = 1'b0;
    logic [7:0]            i_text_byte = 8'd0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [7:0]            o_out_char;
    logic                  o_char_valid;
    logic                  o_fault;
    logic                  o_last;

    // Characters still owed by the block, oldest first.
    char_beat_t char_queue[$];

    // Writer state as the bench sees it.
    t_gram             doc_state   = G_START;
    logic [NEST-1:0]   open_kinds  = '0;
    int                open_count  = 0;
    logic              in_string   = 1'b0;
    t_role             string_role = ROLE_TOP;
    logic              doc_fault   = 1'b0;

    int   errors          = 0;
    int   cycles          = 0;
    int   stall_left      = 0;
    logic no_idle         = 1'b0;
    logic calm            = 1'b0;
    logic want_long_hold  = 1'b0;
    logic long_hold_done  = 1'b0;

    json_token_serializer_top #(
        .NEST_DEPTH   (NEST),
        .NUMBER_WIDTH (NUMW)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_number     (i_number),
        .i_truth      (i_truth),
        .i_text_byte  (i_text_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_char_valid (o_char_valid),
        .o_fault      (o_fault),
        .o_last       (o_last)
    );

    // Clock with a 10 unit period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Work out the characters one accepted event writes and queue them.
    task automatic serialize_event(input logic [3:0] mode, input logic [63:0] number,
                                   input logic truth, input logic [7:0] tbyte);
        logic [7:0]  chars[$];
        logic [7:0]  digits[$];
        logic [63:0] mag;
        logic [63:0] rem;
        logic        bad;
        t_gram       g;
        string       w;
        char_beat_t  beat;
        bad = 1'b0;
        g   = doc_state;
        if (doc_fault || g == G_ERR || mode > MODE_STR_END) begin
            bad = 1'b1;
        end else if (in_string != (mode == MODE_STR_BYTE || mode == MODE_STR_END)) begin
            bad = 1'b1;
        end else begin
            case (mode)
                MODE_OBJ_START, MODE_ARR_START: begin
                    if ((g != G_START && g != G_OBJ_KEY && g != G_ARR && g != G_ARR_ITEM)
                        || open_count >= NEST) begin
                        bad = 1'b1;
                    end else begin
                        if (g == G_ARR_ITEM) chars.push_back(CH_COMMA);
                        chars.push_back(mode == MODE_OBJ_START ? CH_LBRACE : CH_LBRACK);
                        open_kinds[open_count] = (mode == MODE_OBJ_START) ? KIND_OBJ : KIND_ARR;
                        open_count++;
                        doc_state = (mode == MODE_OBJ_START) ? G_OBJ : G_ARR;
                    end
                end
                MODE_OBJ_END, MODE_ARR_END: begin
                    if ((mode == MODE_OBJ_END && g != G_OBJ && g != G_OBJ_VAL)
                        || (mode == MODE_ARR_END && g != G_ARR && g != G_ARR_ITEM)
                        || open_count == 0) begin
                        bad = 1'b1;
                    end else begin
                        chars.push_back(mode == MODE_OBJ_END ? CH_RBRACE : CH_RBRACK);
                        open_count--;
                        // The parent container decides where the grammar resumes.
                        if (open_count == 0)
                            doc_state = G_END;
                        else if (open_kinds[open_count - 1] == KIND_ARR)
                            doc_state = G_ARR_ITEM;
                        else
                            doc_state = G_OBJ_VAL;
                    end
                end
                MODE_INT, MODE_BOOL, MODE_NULL: begin
                    if (g == G_START)
                        doc_state = G_END;
                    else if (g == G_ARR || g == G_ARR_ITEM)
                        doc_state = G_ARR_ITEM;
                    else if (g == G_OBJ_KEY)
                        doc_state = G_OBJ_VAL;
                    else
                        bad = 1'b1;
                    if (!bad) begin
                        if (g == G_ARR_ITEM) chars.push_back(CH_COMMA);
                        if (mode == MODE_INT) begin
                            // Decimal digits, most significant first, with a sign.
                            mag = number;
                            if (number[63]) begin
                                chars.push_back(CH_MINUS);
                                mag = ~number + 64'd1;
                            end
                            do begin
                                rem = mag % 64'd10;
                                digits.push_front(CH_ZERO + rem[7:0]);
                                mag = mag / 64'd10;
                            end while (mag != 64'd0);
                            foreach (digits[k]) chars.push_back(digits[k]);
                        end else begin
                            if (mode == MODE_NULL)
                                w = "null";
                            else if (truth)
                                w = "true";
                            else
                                w = "false";
                            for (int k = 0; k < w.len(); k++) chars.push_back(w[k]);
                        end
                    end
                end
                MODE_STR_BEGIN: begin
                    if (g == G_START)
                        string_role = ROLE_TOP;
                    else if (g == G_ARR || g == G_ARR_ITEM)
                        string_role = ROLE_ITEM;
                    else if (g == G_OBJ || g == G_OBJ_VAL)
                        string_role = ROLE_KEY;
                    else if (g == G_OBJ_KEY)
                        string_role = ROLE_VAL;
                    else
                        bad = 1'b1;
                    if (!bad) begin
                        if (g == G_ARR_ITEM || g == G_OBJ_VAL) chars.push_back(CH_COMMA);
                        chars.push_back(CH_QUOTE);
                        in_string = 1'b1;
                    end
                end
                MODE_STR_BYTE: begin
                    chars.push_back(tbyte);
                end
                default: begin
                    // Closing quote; a key is followed by its colon.
                    chars.push_back(CH_QUOTE);
                    if (string_role == ROLE_KEY) chars.push_back(CH_COLON);
                    case (string_role)
                        ROLE_TOP:  doc_state = G_END;
                        ROLE_ITEM: doc_state = G_ARR_ITEM;
                        ROLE_KEY:  doc_state = G_OBJ_KEY;
                        default:   doc_state = G_OBJ_VAL;
                    endcase
                    in_string = 1'b0;
                end
            endcase
        end

        if (bad) begin
            doc_fault  = 1'b1;
            doc_state  = G_ERR;
            beat.ch       = 8'd0;
            beat.ch_valid = 1'b0;
            beat.fault    = 1'b1;
            beat.last     = 1'b1;
            char_queue.push_back(beat);
        end else begin
            for (int k = 0; k < chars.size(); k++) begin
                beat.ch       = chars[k];
                beat.ch_valid = 1'b1;
                beat.fault    = 1'b0;
                beat.last     = (k == chars.size() - 1);
                char_queue.push_back(beat);
            end
        end
    endtask

    // Offer one event and hold it until the block takes the beat.
    task automatic put_event(input logic [3:0] mode, input logic [63:0] number,
                             input logic truth, input logic [7:0] tbyte);
        int gap;
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_number    <= number;
        i_truth     <= truth;
        i_text_byte <= tbyte;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        serialize_event(mode, number, truth, tbyte);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Event whose unused fields carry random junk.
    task automatic put_mode(input logic [3:0] mode);
        put_event(mode, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
    endtask

    // Integer values: small, full range, extremes and sign-extended short words.
    function automatic logic [63:0] pick_number();
        logic [63:0] v;
        int          sh;
        case ($urandom_range(0, 3))
            0: begin
                v = 64'($urandom_range(0, 199));
                v = v - 64'd100;
            end
            1: v = {$urandom, $urandom};
            2: begin
                case ($urandom_range(0, 5))
                    0:       v = 64'd0;
                    1:       v = '1;
                    2:       v = 64'h8000_0000_0000_0000;
                    3:       v = 64'h7FFF_FFFF_FFFF_FFFF;
                    4:       v = 64'h8000_0000_0000_0001;
                    default: v = 64'd1000000000000000000;
                endcase
            end
            default: begin
                sh = $urandom_range(1, 63);
                v  = {$urandom, $urandom};
                v  = $signed(v << sh) >>> sh;
            end
        endcase
        return v;
    endfunction

    // One legal event chosen from the current position in the document.
    task automatic put_legal_random(input int depth_cap);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (in_string) begin
            if (r < 70)
                put_event(MODE_STR_BYTE, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
            else
                put_mode(MODE_STR_END);
        end else if (doc_state == G_OBJ || doc_state == G_OBJ_VAL) begin
            if (r < 65)
                put_mode(MODE_STR_BEGIN);
            else
                put_mode(MODE_OBJ_END);
        end else if (doc_state != G_OBJ_KEY && open_count > 1 && r < 15) begin
            put_mode(MODE_ARR_END);
        end else begin
            // A value in an array or after a key.
            v = $urandom_range(0, 99);
            if (v < 25)
                put_event(MODE_INT, pick_number(), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
            else if (v < 35)
                put_mode(MODE_BOOL);
            else if (v < 43)
                put_mode(MODE_NULL);
            else if (v < 70)
                put_mode(MODE_STR_BEGIN);
            else if (open_count >= depth_cap)
                put_mode(MODE_NULL);
            else if (v < 85)
                put_mode(MODE_OBJ_START);
            else
                put_mode(MODE_ARR_START);
        end
    endtask

    // Open containers, adding keys where an object needs one, up to a depth.
    task automatic fill_to(input int target);
        while (open_count < target) begin
            if (in_string)
                put_mode(MODE_STR_END);
            else if (doc_state == G_OBJ || doc_state == G_OBJ_VAL)
                put_mode(MODE_STR_BEGIN);
            else if ($urandom_range(0, 3) == 0)
                put_mode(MODE_OBJ_START);
            else
                put_mode(MODE_ARR_START);
        end
    endtask

    // Close containers down to a depth, finishing any open string or key.
    task automatic drain_to(input int target);
        while (open_count > target || in_string || doc_state == G_OBJ_KEY) begin
            if (in_string)
                put_mode(MODE_STR_END);
            else if (doc_state == G_OBJ_KEY)
                put_mode(MODE_NULL);
            else if (doc_state == G_OBJ || doc_state == G_OBJ_VAL)
                put_mode(MODE_OBJ_END);
            else
                put_mode(MODE_ARR_END);
        end
    endtask

    // Compare one field of a result beat.
    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    // Result side: check each beat and choose the next ready level.
    always @(posedge i_clk) begin : take_results
        char_beat_t want;
        if (o_valid === 1'b1 && i_ready) begin
            if (char_queue.size() == 0) begin
                $display("%0t: beat with nothing expected: char %h valid %b fault %b last %b",
                         $time, o_out_char, o_char_valid, o_fault, o_last);
                errors++;
            end else begin
                want = char_queue.pop_front();
                compare_field("out_char", want.ch, o_out_char);
                compare_field("char_valid", 8'(want.ch_valid), 8'(o_char_valid));
                compare_field("fault", 8'(want.fault), 8'(o_fault));
                compare_field("last", 8'(want.last), 8'(o_last));
            end
        end

        if (want_long_hold && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!no_idle && !calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0) calm = !calm;
    end

    // Extremes of every value kind; strings as items, keys and values; containers in each position.
    task automatic test_directed_values();
        put_mode(MODE_ARR_START);
        put_event(MODE_INT, 64'd0, 1'b0, 8'd0);
        put_event(MODE_INT, '1, 1'b1, 8'hFF);
        put_event(MODE_INT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 8'd0);
        put_event(MODE_INT, 64'h8000_0000_0000_0000, 1'b1, 8'hFF);
        put_event(MODE_BOOL, '1, 1'b1, 8'hFF);
        put_event(MODE_BOOL, '0, 1'b0, 8'h00);
        put_mode(MODE_NULL);
        put_mode(MODE_STR_BEGIN);
        put_event(MODE_STR_BYTE, '0, 1'b0, 8'h00);
        put_event(MODE_STR_BYTE, '1, 1'b1, 8'hFF);
        put_mode(MODE_STR_END);
        // Empty string as an array item.
        put_mode(MODE_STR_BEGIN);
        put_mode(MODE_STR_END);
        // Object holding a key with an empty array, then a second key with a string value.
        put_mode(MODE_OBJ_START);
        put_mode(MODE_STR_BEGIN);
        put_mode(MODE_STR_END);
        put_mode(MODE_ARR_START);
        put_mode(MODE_ARR_END);
        put_mode(MODE_STR_BEGIN);
        put_mode(MODE_STR_END);
        put_mode(MODE_STR_BEGIN);
        put_mode(MODE_STR_END);
        put_mode(MODE_OBJ_END);
        // Empty containers as array items.
        put_mode(MODE_ARR_START);
        put_mode(MODE_ARR_END);
        put_mode(MODE_OBJ_START);
        put_mode(MODE_OBJ_END);
    endtask

    // Random well-formed content inside the top array; one long output stall.
    task automatic test_random_document();
        for (int n = 0; n < 60; n++) begin
            if (n == 20) want_long_hold = 1'b1;
            put_legal_random($urandom_range(2, 7));
        end
        drain_to(1);
    endtask

    // Nest to the full stack depth and unwind back to the top array.
    task automatic test_full_depth();
        fill_to(NEST);
        drain_to(1);
    endtask

    // One start past the full stack must fault.
    task automatic test_overflow();
        fill_to(NEST);
        if (in_string) put_mode(MODE_STR_END);
        if (doc_state == G_OBJ || doc_state == G_OBJ_VAL) begin
            put_mode(MODE_STR_BEGIN);
            put_mode(MODE_STR_END);
        end
        put_mode($urandom_range(0, 1) ? MODE_OBJ_START : MODE_ARR_START);
    endtask

    // After the fault every event, meaningful or not, gives one fault beat.
    task automatic test_after_fault();
        put_mode(MODE_UNUSED_LO);
        put_mode(MODE_UNUSED_HI);
        for (int n = 0; n < 18; n++)
            put_mode(4'($urandom_range(0, 15)));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_values();
        test_random_document();
        test_full_depth();
        // The tail runs with both sides always ready.
        no_idle = 1'b1;
        test_overflow();
        test_after_fault();
        i_valid <= 1'b0;

        while (char_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
